// ===== rtl/chp_pkg.sv =====
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types and constants of the chunk size line parser.
// ----------------------------------------------------------------------------
package chp_pkg;

  // queue depths
  localparam int TokQueueDepth = 4;
  localparam int ResQueueDepth = 2;

  // configuration register indexes
  localparam logic [2:0] CfgStrictLineEnd = 3'd0;
  localparam logic [2:0] CfgMaxWhitespace = 3'd1;
  localparam logic [2:0] CfgMaxDigits     = 3'd2;
  localparam logic [2:0] CfgMaxLineLength = 3'd3;
  localparam logic [2:0] CfgMaxChunkSize  = 3'd4;

  // configuration reset values
  localparam logic        StrictLineEndRst = 1'b0;
  localparam logic [7:0]  MaxWhitespaceRst = 8'd8;
  localparam logic [4:0]  MaxDigitsRst     = 5'd16;
  localparam logic [15:0] MaxLineLengthRst = 16'd1024;
  localparam logic [63:0] MaxChunkSizeRst  = 64'hFFFF_FFFF_FFFF_FFFF;

  // counter limits
  localparam logic [16:0] LineCountMax  = 17'h1FFFF;
  localparam logic [8:0]  SpaceCountMax = 9'h1FF;
  localparam logic [4:0]  HardDigitMax  = 5'd16;

  // ASCII codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSemi  = 8'h3B;

  typedef enum logic [3:0] {
    PH_LEAD_WS  = 4'd0,
    PH_SIZE     = 4'd1,
    PH_EXT_WS   = 4'd2,
    PH_EXT      = 4'd3,
    PH_AWAIT_LF = 4'd4,
    PH_VALID    = 4'd5,
    PH_ERR_LEN  = 4'd6,
    PH_ERR_WS   = 4'd7,
    PH_ERR_SIZE = 4'd8,
    PH_ERR_CRLF = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_HEX,
    CLS_SEMI,
    CLS_CR,
    CLS_LF,
    CLS_OTHER
  } byte_cls_t;

  // one classified byte, front to back
  typedef struct packed {
    logic      start;
    byte_cls_t cls;
    logic [3:0] hex_val;
  } tok_t;

  // one result
  typedef struct packed {
    logic        accepted;
    logic [3:0]  phase;
    logic [63:0] size_value;
    logic        size_known;
  } res_t;

  // configuration registers
  typedef struct packed {
    logic        strict_line_end;
    logic [7:0]  max_whitespace;
    logic [4:0]  max_digits;
    logic [15:0] max_line_length;
    logic [63:0] max_size;
  } cfg_t;

endpackage

// ===== rtl/chunk_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// chunk_header_parser_core
// Chunked transfer size line parser: one byte in, one status result out.
// ----------------------------------------------------------------------------
// Bytes are pushed on the in_ side and each one gives exactly one result on
// the out_ side, in order. Sustained rate is one byte per clock: the parser
// state machine takes one classified byte from the internal byte queue in
// every cycle that the result queue has room. A pushed byte is registered in
// the byte queue and its result then in the result queue (empty low). Set
// in_start_req on the first byte of a new line. Write the configuration only
// while no request is in flight; there is no clearing pass after reset.
module chunk_header_parser_core #(
  parameter int TokDepth = chp_pkg::TokQueueDepth,
  parameter int ResDepth = chp_pkg::ResQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // input requests
  input  logic        push,
  output logic        full,
  input  logic        in_start_req,
  input  logic [7:0]  in_byte_in,
  // results
  output logic        empty,
  input  logic        pop,
  output logic        out_accepted,
  output logic [3:0]  out_phase,
  output logic [63:0] out_size_value,
  output logic        out_size_known
);

  chp_pkg::cfg_t cfg_r;
  chp_pkg::tok_t tok;
  chp_pkg::res_t res, res_q;
  logic          tok_valid, tok_pop, res_push, res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strict_line_end <= chp_pkg::StrictLineEndRst;
      cfg_r.max_whitespace  <= chp_pkg::MaxWhitespaceRst;
      cfg_r.max_digits      <= chp_pkg::MaxDigitsRst;
      cfg_r.max_line_length <= chp_pkg::MaxLineLengthRst;
      cfg_r.max_size        <= chp_pkg::MaxChunkSizeRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        chp_pkg::CfgStrictLineEnd: cfg_r.strict_line_end <= cfg_wdata[0];
        chp_pkg::CfgMaxWhitespace: cfg_r.max_whitespace  <= cfg_wdata[7:0];
        chp_pkg::CfgMaxDigits:     cfg_r.max_digits      <= cfg_wdata[4:0];
        chp_pkg::CfgMaxLineLength: cfg_r.max_line_length <= cfg_wdata[15:0];
        chp_pkg::CfgMaxChunkSize:  cfg_r.max_size        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // classifier and byte queue
  chp_front #(
    .TokDepth (TokDepth)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .start_req (in_start_req),
    .byte_in   (in_byte_in),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  // parser state machine
  chp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result queue
  chp_fifo #(
    .Width ($bits(chp_pkg::res_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign out_accepted   = res_q.accepted;
  assign out_phase      = res_q.phase;
  assign out_size_value = res_q.size_value;
  assign out_size_known = res_q.size_known;

endmodule

// ===== rtl/chp_fifo.sv =====
// ----------------------------------------------------------------------------
// chp_fifo
// Small first-in first-out queue on a register array, full/empty flags.
// ----------------------------------------------------------------------------
module chp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/chp_front.sv =====
// ----------------------------------------------------------------------------
// chp_front
// Takes input requests, classifies each byte and queues it for the parser.
// ----------------------------------------------------------------------------
module chp_front #(
  parameter int TokDepth = chp_pkg::TokQueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic          start_req,
  input  logic [7:0]    byte_in,
  output logic          tok_valid,
  output chp_pkg::tok_t tok,
  input  logic          tok_pop
);

  chp_pkg::tok_t tok_in;
  logic          tok_empty;

  // byte classification and hex value
  always_comb begin
    tok_in.start   = start_req;
    tok_in.hex_val = 4'd0;
    if (byte_in == chp_pkg::ChSpace || byte_in == chp_pkg::ChTab) begin
      tok_in.cls = chp_pkg::CLS_BLANK;
    end else if (byte_in inside {[8'h30:8'h39]}) begin
      tok_in.cls     = chp_pkg::CLS_HEX;
      tok_in.hex_val = byte_in[3:0];
    end else if (byte_in inside {[8'h41:8'h46]}) begin
      tok_in.cls     = chp_pkg::CLS_HEX;
      tok_in.hex_val = 4'(byte_in - 8'h37);
    end else if (byte_in inside {[8'h61:8'h66]}) begin
      tok_in.cls     = chp_pkg::CLS_HEX;
      tok_in.hex_val = 4'(byte_in - 8'h57);
    end else if (byte_in == chp_pkg::ChSemi) begin
      tok_in.cls = chp_pkg::CLS_SEMI;
    end else if (byte_in == chp_pkg::ChCr) begin
      tok_in.cls = chp_pkg::CLS_CR;
    end else if (byte_in == chp_pkg::ChLf) begin
      tok_in.cls = chp_pkg::CLS_LF;
    end else begin
      tok_in.cls = chp_pkg::CLS_OTHER;
    end
  end

  // queue between classifier and parser
  chp_fifo #(
    .Width ($bits(chp_pkg::tok_t)),
    .Depth (TokDepth)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .rdata (tok),
    .empty (tok_empty)
  );

  assign tok_valid = ~tok_empty;

endmodule

// ===== rtl/chp_back.sv =====
// ----------------------------------------------------------------------------
// chp_back
// Parser state machine: consumes one classified byte per cycle while the result queue has room, emits result.
// ----------------------------------------------------------------------------
module chp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  chp_pkg::cfg_t cfg,
  input  logic          tok_valid,
  input  chp_pkg::tok_t tok,
  output logic          tok_pop,
  output logic          res_push,
  output chp_pkg::res_t res,
  input  logic          res_full
);

  chp_pkg::phase_t phase_r, phase_nxt;
  logic [16:0]     line_cnt_r, line_cnt_nxt;
  logic [8:0]      space_cnt_r, space_cnt_nxt;
  logic [4:0]      digit_cnt_r, digit_cnt_nxt;
  logic [63:0]     size_acc_r, size_acc_nxt;
  logic            size_done_r, size_done_nxt;
  logic            ok;
  logic            consume;

  chp_pkg::phase_t ph_base, ph_cur;
  logic [16:0]     lc_base;
  logic [8:0]      sc_base, sc_inc;
  logic [4:0]      dc_base, dc_inc, dig_lim;
  logic [63:0]     acc_base;
  logic            done_base;
  logic            ws_ok, is_blank, run_size, run_ext;

  assign consume  = tok_valid & ~res_full;
  assign tok_pop  = consume;
  assign res_push = consume;

  // next parser state for the byte at the head of the queue
  always_comb begin
    ph_base   = tok.start ? chp_pkg::PH_LEAD_WS : phase_r;
    lc_base   = tok.start ? '0 : line_cnt_r;
    sc_base   = tok.start ? '0 : space_cnt_r;
    dc_base   = tok.start ? '0 : digit_cnt_r;
    acc_base  = tok.start ? '0 : size_acc_r;
    done_base = tok.start ? 1'b0 : size_done_r;

    line_cnt_nxt = lc_base + {16'd0, (lc_base != chp_pkg::LineCountMax)};
    ph_cur = (line_cnt_nxt > {1'b0, cfg.max_line_length}) ? chp_pkg::PH_ERR_LEN : ph_base;

    sc_inc  = sc_base + {8'd0, (sc_base != chp_pkg::SpaceCountMax)};
    ws_ok   = (sc_inc <= {1'b0, cfg.max_whitespace});
    dig_lim = (cfg.max_digits > chp_pkg::HardDigitMax) ? chp_pkg::HardDigitMax
                                                        : cfg.max_digits;
    dc_inc  = dc_base + 5'd1;

    is_blank = (tok.cls == chp_pkg::CLS_BLANK);
    run_size = (ph_cur == chp_pkg::PH_SIZE) ||
               (ph_cur == chp_pkg::PH_LEAD_WS && !is_blank);
    run_ext  = (ph_cur == chp_pkg::PH_EXT) ||
               (ph_cur == chp_pkg::PH_EXT_WS && !is_blank);

    phase_nxt     = ph_cur;
    space_cnt_nxt = sc_base;
    digit_cnt_nxt = dc_base;
    size_acc_nxt  = acc_base;
    size_done_nxt = done_base;
    ok            = 1'b0;

    if (ph_cur == chp_pkg::PH_LEAD_WS && is_blank) begin
      // leading whitespace
      space_cnt_nxt = sc_inc;
      ok            = ws_ok;
      if (!ws_ok) begin
        phase_nxt = chp_pkg::PH_ERR_WS;
      end
    end else if (run_size) begin
      // size digits and terminator
      phase_nxt = chp_pkg::PH_SIZE;
      case (tok.cls)
        chp_pkg::CLS_HEX: begin
          digit_cnt_nxt = dc_inc;
          if (dc_inc > dig_lim) begin
            phase_nxt = chp_pkg::PH_ERR_SIZE;
          end else begin
            size_acc_nxt = {acc_base[59:0], tok.hex_val};
            ok           = 1'b1;
          end
        end
        chp_pkg::CLS_SEMI, chp_pkg::CLS_CR, chp_pkg::CLS_LF: begin
          size_done_nxt = 1'b1;
          if (acc_base > cfg.max_size) begin
            phase_nxt = chp_pkg::PH_ERR_SIZE;
          end else if (tok.cls == chp_pkg::CLS_SEMI) begin
            space_cnt_nxt = '0;
            phase_nxt     = chp_pkg::PH_EXT_WS;
            ok            = 1'b1;
          end else if (tok.cls == chp_pkg::CLS_CR) begin
            phase_nxt = chp_pkg::PH_AWAIT_LF;
            ok        = 1'b1;
          end else if (!cfg.strict_line_end) begin
            phase_nxt = chp_pkg::PH_VALID;
            ok        = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end else if (ph_cur == chp_pkg::PH_EXT_WS && is_blank) begin
      // extension whitespace, phase holds on overflow
      space_cnt_nxt = sc_inc;
      ok            = ws_ok;
    end else if (run_ext) begin
      // extension text up to line end
      phase_nxt = chp_pkg::PH_EXT;
      ok        = 1'b1;
      if (tok.cls == chp_pkg::CLS_CR) begin
        phase_nxt = chp_pkg::PH_AWAIT_LF;
      end else if (tok.cls == chp_pkg::CLS_LF) begin
        if (cfg.strict_line_end) begin
          phase_nxt = chp_pkg::PH_ERR_CRLF;
          ok        = 1'b0;
        end else begin
          phase_nxt = chp_pkg::PH_VALID;
        end
      end
    end else if (ph_cur == chp_pkg::PH_AWAIT_LF) begin
      if (tok.cls == chp_pkg::CLS_LF) begin
        phase_nxt = chp_pkg::PH_VALID;
        ok        = 1'b1;
      end
    end
  end

  // result for the consumed byte
  always_comb begin
    res.accepted   = ok;
    res.phase      = phase_nxt;
    res.size_value = size_acc_nxt;
    res.size_known = size_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= chp_pkg::PH_LEAD_WS;
      line_cnt_r  <= '0;
      space_cnt_r <= '0;
      digit_cnt_r <= '0;
      size_acc_r  <= '0;
      size_done_r <= 1'b0;
    end else if (consume) begin
      phase_r     <= phase_nxt;
      line_cnt_r  <= line_cnt_nxt;
      space_cnt_r <= space_cnt_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      size_acc_r  <= size_acc_nxt;
      size_done_r <= size_done_nxt;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks chunk_header_parser_core against its own status predictor. Size lines
// are generated as byte requests (mostly well-formed, some noise and broken
// lines), pushed with random gaps, and every status popped is compared with
// the predicted one. Limits are reloaded between bursts of traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WatchLimit = 2000;
  localparam int LongHold   = 150;
  localparam logic [2:0] CfgUnused = 3'd7;

  // one byte request as queued for the driver
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } byte_req_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        push = 1'b0;
  logic        full;
  logic        in_start_req = 1'b0;
  logic [7:0]  in_byte_in = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_accepted;
  logic [3:0]  out_phase;
  logic [63:0] out_size_value;
  logic        out_size_known;

  chunk_header_parser_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_start_req   (in_start_req),
    .in_byte_in     (in_byte_in),
    .empty          (empty),
    .pop            (pop),
    .out_accepted   (out_accepted),
    .out_phase      (out_phase),
    .out_size_value (out_size_value),
    .out_size_known (out_size_known)
  );

  // clock, period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // stimulus and expectation stores
  byte_req_t     byte_backlog[$];
  chp_pkg::res_t pending_status[$];
  logic          next_start = 1'b0;
  int unsigned   queued = 0;
  int unsigned   idle_pct = 0;
  logic          hold_req = 1'b0;
  logic          byte_taken = 1'b0;
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   send_gap = 0;
  int unsigned   recv_gap = 0;
  int unsigned   hold_left = 0;

  // predictor limits
  logic        lim_strict;
  logic [7:0]  lim_blanks;
  logic [4:0]  lim_digits;
  logic [15:0] lim_line;
  logic [63:0] lim_size;

  // predictor state
  chp_pkg::phase_t ph;
  logic [16:0]     line_len;
  logic [8:0]      blank_run;
  logic [4:0]      digit_run;
  logic [63:0]     size_val;
  logic            size_seen;

  function automatic void clear_parse();
    ph        = chp_pkg::PH_LEAD_WS;
    line_len  = '0;
    blank_run = '0;
    digit_run = '0;
    size_val  = '0;
    size_seen = 1'b0;
  endfunction

  // one more space or tab, still within the limit?
  function automatic logic count_blank();
    if (blank_run != chp_pkg::SpaceCountMax) blank_run++;
    return blank_run <= {1'b0, lim_blanks};
  endfunction

  // status that one byte request gives, advancing the parser state
  function automatic chp_pkg::res_t parse_byte(input logic start, input logic [7:0] c);
    chp_pkg::res_t r;
    logic          ok;
    logic          blank;
    logic          handled;
    logic [4:0]    hex;
    logic [4:0]    dig_cap;
    ok      = 1'b0;
    handled = 1'b0;
    blank   = (c == chp_pkg::ChSpace) || (c == chp_pkg::ChTab);
    if (c >= "0" && c <= "9") hex = 5'(c - "0");
    else if (c >= "A" && c <= "F") hex = 5'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") hex = 5'(c - "a" + 8'd10);
    else hex = 5'd16;
    if (start) clear_parse();
    // line length check overrides any phase
    if (line_len != chp_pkg::LineCountMax) line_len++;
    if (line_len > {1'b0, lim_line}) ph = chp_pkg::PH_ERR_LEN;
    if (ph == chp_pkg::PH_LEAD_WS) begin
      if (blank) begin
        ok = count_blank();
        if (!ok) ph = chp_pkg::PH_ERR_WS;
        handled = 1'b1;
      end else begin
        ph = chp_pkg::PH_SIZE;
      end
    end
    // size digits and the size terminator
    if (!handled && ph == chp_pkg::PH_SIZE) begin
      handled = 1'b1;
      dig_cap = (lim_digits > chp_pkg::HardDigitMax) ? chp_pkg::HardDigitMax : lim_digits;
      if (hex != 5'd16) begin
        digit_run++;
        if (digit_run > dig_cap) begin
          ph = chp_pkg::PH_ERR_SIZE;
        end else begin
          size_val = {size_val[59:0], hex[3:0]};
          ok = 1'b1;
        end
      end else if (c == chp_pkg::ChSemi || c == chp_pkg::ChCr || c == chp_pkg::ChLf) begin
        size_seen = 1'b1;
        if (size_val > lim_size) begin
          ph = chp_pkg::PH_ERR_SIZE;
        end else if (c == chp_pkg::ChSemi) begin
          blank_run = '0;
          ph = chp_pkg::PH_EXT_WS;
          ok = 1'b1;
        end else if (c == chp_pkg::ChCr) begin
          ph = chp_pkg::PH_AWAIT_LF;
          ok = 1'b1;
        end else if (!lim_strict) begin
          ph = chp_pkg::PH_VALID;
          ok = 1'b1;
        end
      end
    end
    // extension: blanks, then free text up to the line end
    if (!handled && ph == chp_pkg::PH_EXT_WS) begin
      if (blank) begin
        ok = count_blank();
        handled = 1'b1;
      end else begin
        ph = chp_pkg::PH_EXT;
      end
    end
    if (!handled && ph == chp_pkg::PH_EXT) begin
      handled = 1'b1;
      ok = 1'b1;
      if (c == chp_pkg::ChCr) begin
        ph = chp_pkg::PH_AWAIT_LF;
      end else if (c == chp_pkg::ChLf) begin
        if (lim_strict) begin
          ph = chp_pkg::PH_ERR_CRLF;
          ok = 1'b0;
        end else begin
          ph = chp_pkg::PH_VALID;
        end
      end
    end
    if (!handled && ph == chp_pkg::PH_AWAIT_LF && c == chp_pkg::ChLf) begin
      ph = chp_pkg::PH_VALID;
      ok = 1'b1;
    end
    r.accepted   = ok;
    r.phase      = ph;
    r.size_value = size_val;
    r.size_known = size_seen;
    return r;
  endfunction

  // monitor: limits, accepted requests, popped statuses, watchdog
  always @(posedge clk) begin : watch_outputs
    chp_pkg::res_t want;
    chp_pkg::res_t got;
    logic          result_taken;
    byte_taken   = 1'b0;
    result_taken = 1'b0;
    if (rst_n !== 1'b1) begin
      clear_parse();
      lim_strict = chp_pkg::StrictLineEndRst;
      lim_blanks = chp_pkg::MaxWhitespaceRst;
      lim_digits = chp_pkg::MaxDigitsRst;
      lim_line   = chp_pkg::MaxLineLengthRst;
      lim_size   = chp_pkg::MaxChunkSizeRst;
      quiet_cycles = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          chp_pkg::CfgStrictLineEnd: lim_strict = cfg_wdata[0];
          chp_pkg::CfgMaxWhitespace: lim_blanks = cfg_wdata[7:0];
          chp_pkg::CfgMaxDigits:     lim_digits = cfg_wdata[4:0];
          chp_pkg::CfgMaxLineLength: lim_line   = cfg_wdata[15:0];
          chp_pkg::CfgMaxChunkSize:  lim_size   = cfg_wdata;
          default: ;
        endcase
      end
      if (push && !full) begin
        byte_taken = 1'b1;
        pending_status.insert(pending_status.size(), parse_byte(in_start_req, in_byte_in));
      end
      if (pop && !empty) begin
        result_taken = 1'b1;
        got = {out_accepted, out_phase, out_size_value, out_size_known};
        if (pending_status.size() == 0) begin
          mismatches++;
          $display("%0t status with no request waiting: acc=%0b phase=%0d size=%h known=%0b",
                   $time, got.accepted, got.phase, got.size_value, got.size_known);
        end else begin
          want = pending_status.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t status mismatch: expected acc=%0b phase=%0d size=%h known=%0b, %s",
                     $time, want.accepted, want.phase, want.size_value, want.size_known,
                     $sformatf("actual acc=%0b phase=%0d size=%h known=%0b",
                               got.accepted, got.phase, got.size_value, got.size_known));
          end
        end
      end
      if (byte_taken || result_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t no handshake for %0d cycles", $time, WatchLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // driver: one byte request per push, random gaps
  always @(negedge clk) begin : drive_requests
    byte_req_t head;
    if (byte_taken) head = byte_backlog.pop_front();
    if (rst_n !== 1'b1) begin
      push <= 1'b0;
    end else if (send_gap != 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      send_gap = $urandom_range(0, 8);
      push <= 1'b0;
    end else if (byte_backlog.size() != 0) begin
      head = byte_backlog[0];
      push <= 1'b1;
      in_start_req <= head.start;
      in_byte_in <= head.data;
    end else begin
      push <= 1'b0;
    end
  end

  // receiver: random stalls, and one long hold when asked
  always @(negedge clk) begin : drain_statuses
    if (hold_req) begin
      hold_left = LongHold;
      hold_req = 1'b0;
    end
    if (rst_n !== 1'b1) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(0, 8);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic put(input logic [7:0] b);
    byte_req_t r;
    r.start = next_start;
    r.data  = b;
    byte_backlog.insert(byte_backlog.size(), r);
    next_start = 1'b0;
    queued++;
  endtask

  function automatic logic [7:0] pick_hex();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return "0" + 8'(k);
    if (k < 16) return "a" + 8'(k - 10);
    return "A" + 8'(k - 16);
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? chp_pkg::ChSpace : chp_pkg::ChTab;
  endfunction

  // blank run: mostly short, sometimes one past the limit when the limit is 12 or less
  function automatic int unsigned pick_blank_run();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return (lim_blanks > 12) ? $urandom_range(4, 12) : lim_blanks + 1;
    if (r < 5) return 0;
    return $urandom_range(1, 3);
  endfunction

  // one size line: well-formed with random content, noise, or a broken tail
  task automatic queue_line();
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    int unsigned eff;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    next_start = ($urandom_range(0, 19) != 0);
    if (kind < 75) begin
      n = pick_blank_run();
      repeat (n) put(pick_blank());
      eff = (lim_digits > 16) ? 16 : lim_digits;
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r == 1) n = eff + 1;
      else if (r < 6) n = $urandom_range(1, 3);
      else n = $urandom_range(1, (eff == 0) ? 1 : eff);
      repeat (n) put(pick_hex());
      // optional extension
      if ($urandom_range(0, 9) < 4) begin
        put(chp_pkg::ChSemi);
        n = pick_blank_run();
        repeat (n) put(pick_blank());
        n = $urandom_range(0, 5);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == chp_pkg::ChCr || b == chp_pkg::ChLf) b = "x";
          put(b);
        end
      end
      // line end: CR LF, bare LF, or junk between CR and LF
      r = $urandom_range(0, 9);
      if (r < 7) begin
        put(chp_pkg::ChCr);
        put(chp_pkg::ChLf);
      end else if (r < 9) begin
        put(chp_pkg::ChLf);
      end else begin
        put(chp_pkg::ChCr);
        b = 8'($urandom_range(0, 255));
        put((b == chp_pkg::ChLf) ? 8'h00 : b);
        put(chp_pkg::ChLf);
      end
      if ($urandom_range(0, 99) < 15) put(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      n = $urandom_range(1, 8);
      repeat (n) put(8'($urandom_range(0, 255)));
    end else begin
      // continuation bytes with no new line
      next_start = 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: put(chp_pkg::ChCr);
          1: put(chp_pkg::ChLf);
          2: put(chp_pkg::ChSemi);
          3: put(pick_blank());
          4: put(pick_hex());
          default: put(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic fill_backlog(input int unsigned n_bytes);
    @(posedge clk);
    queued = 0;
    while (queued < n_bytes) queue_line();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || pending_status.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // write every limit register, junk in the unused data bits
  task automatic load_limits(input logic s_strict, input logic [7:0] s_blanks,
                             input logic [4:0] s_digits, input logic [15:0] s_line,
                             input logic [63:0] s_size);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= chp_pkg::CfgStrictLineEnd;
    cfg_wdata <= {junk[63:1], s_strict};
    @(negedge clk);
    cfg_index <= chp_pkg::CfgMaxWhitespace;
    cfg_wdata <= {junk[63:8], s_blanks};
    @(negedge clk);
    cfg_index <= chp_pkg::CfgMaxDigits;
    cfg_wdata <= {junk[63:5], s_digits};
    @(negedge clk);
    cfg_index <= chp_pkg::CfgMaxLineLength;
    cfg_wdata <= {junk[63:16], s_line};
    @(negedge clk);
    cfg_index <= chp_pkg::CfgMaxChunkSize;
    cfg_wdata <= s_size;
    @(negedge clk);
    cfg_index <= CfgUnused;
    cfg_wdata <= junk;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : run_phases
    logic [15:0] r_line;
    logic [63:0] r_size;
    int          p;
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = chp_pkg::CfgStrictLineEnd;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset limits: directed lines, one very long extension, then random
    idle_pct = 10;
    @(posedge clk);
    // blanks, mixed-case digits, extension with a blank, CR LF
    next_start = 1'b1;
    put(chp_pkg::ChSpace); put(chp_pkg::ChTab); put("f"); put("F"); put("9");
    put(chp_pkg::ChSemi); put(chp_pkg::ChSpace); put("x"); put(chp_pkg::ChCr);
    put(chp_pkg::ChLf);
    // empty size field closed by a bare LF, then a byte after the line end
    next_start = 1'b1;
    put(chp_pkg::ChLf); put("z");
    // stray byte in the size field, stray byte while waiting for LF
    next_start = 1'b1;
    put("g"); put("A"); put(chp_pkg::ChCr); put("q"); put(chp_pkg::ChLf);
    // byte value extremes
    next_start = 1'b1;
    put(8'hFF); put(8'h00);
    // extension blanks past the saturation of the blank counter
    next_start = 1'b1;
    put("5"); put(chp_pkg::ChSemi);
    repeat (515) put(pick_blank());
    put("x"); put(chp_pkg::ChCr); put(chp_pkg::ChLf);
    fill_backlog(20);
    wait_drained();

    // strict, no blanks, one digit, longest line, zero size limit
    load_limits(1'b1, 8'd0, 5'd1, 16'hFFFF, 64'd0);
    idle_pct = 15;
    fill_backlog(60);
    wait_drained();

    // loose, widest blanks, digit limit above 16, short lines;
    // receiver holds off so the input side backs up
    load_limits(1'b0, 8'd255, 5'd31, 16'd40, '1);
    idle_pct = 5;
    fill_backlog(80);
    hold_req = 1'b1;
    wait_drained();

    load_limits(1'b1, 8'd3, 5'd16, 16'd1024, 64'h0000_0000_00FF_FFFF);
    idle_pct = 30;
    fill_backlog(80);
    wait_drained();

    // no digits and no bytes allowed at all
    load_limits(1'b0, 8'd2, 5'd0, 16'd0, {$urandom, $urandom});
    idle_pct = 10;
    fill_backlog(15);
    wait_drained();

    // random limits
    for (p = 0; p < 3; p++) begin
      case ($urandom_range(0, 2))
        0: r_line = 16'($urandom_range(4, 30));
        1: r_line = 16'd1024;
        default: r_line = 16'hFFFF;
      endcase
      case ($urandom_range(0, 2))
        0: r_size = {$urandom, $urandom};
        1: r_size = (64'd1 << $urandom_range(0, 63)) - 64'd1;
        default: r_size = {32'd0, $urandom};
      endcase
      load_limits(1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 5)),
                  5'($urandom_range(0, 20)), r_line, r_size);
      idle_pct = (p == 1) ? 0 : 8 + 12 * p;
      fill_backlog(60);
      wait_drained();
    end

    // back to reset-like limits, full rate on both sides
    load_limits(chp_pkg::StrictLineEndRst, chp_pkg::MaxWhitespaceRst,
                chp_pkg::MaxDigitsRst, chp_pkg::MaxLineLengthRst,
                chp_pkg::MaxChunkSizeRst);
    idle_pct = 0;
    fill_backlog(50);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
